FILE: hw/rtl/plvs_pkg.sv
package plvs_pkg;

   localparam int EntriesPerBuffer = 64;
   localparam int BufferCount      = 16;
   localparam int SetCount         = 64;
   localparam int PoolSize         = EntriesPerBuffer * BufferCount;
   localparam int EntryAw          = $clog2(PoolSize);
   localparam int LinkW            = EntryAw + 1;
   localparam int LenW             = $clog2(PoolSize + 1);
   localparam int SetAw            = 6;
   localparam int ValueW           = 32;
   localparam int PosW             = 10;
   localparam int CmdW             = 3;

   localparam logic [LinkW-1:0] NilLink = LinkW'(PoolSize);

   typedef enum logic [CmdW-1:0] {
      CMD_ADD     = 3'd0,
      CMD_REMOVE  = 3'd1,
      CMD_EXISTS  = 3'd2,
      CMD_COUNT   = 3'd3,
      CMD_GET_NTH = 3'd4,
      CMD_CLEAR   = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_EMPTY  = 2'd0,
      MODE_DIRECT = 2'd1,
      MODE_LIST   = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type            mode;
      logic [ValueW-1:0]   direct;
      logic [EntryAw-1:0]  head;
      logic [EntryAw-1:0]  tail;
      logic [LenW-1:0]     length;
   } set_rec_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SET_READ,
      ST_DECODE,
      ST_WALK_REQ,
      ST_WALK_CHK,
      ST_RM_LINK,
      ST_RM_FREE,
      ST_COL_REQ,
      ST_COL_CHK,
      ST_AL1_REQ,
      ST_AL1_GET,
      ST_AL2_REQ,
      ST_AL2_GET,
      ST_PRO_W1,
      ST_PRO_W2,
      ST_APPEND,
      ST_SET_WRITE,
      ST_DONE
   } ctl_state_type;

   typedef enum logic [2:0] {
      REC_HOLD,
      REC_LOAD,
      REC_DIRECT,
      REC_EMPTY,
      REC_PROMOTE,
      REC_APPEND,
      REC_UNLINK,
      REC_COLLAPSE
   } rec_op_type;

   typedef enum logic [1:0] {
      WALK_HOLD,
      WALK_START,
      WALK_NEXT
   } walk_op_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_CUR,
      RD_FREE,
      RD_HEAD
   } rd_sel_type;

   typedef enum logic [2:0] {
      LW_NONE,
      LW_PREV_NXT,
      LW_GIVE_CUR,
      LW_GIVE_HEAD,
      LW_A_B,
      LW_TAIL_B
   } link_wr_type;

   typedef enum logic [1:0] {
      VW_NONE,
      VW_A_DIRECT,
      VW_B_VALUE
   } val_wr_type;

   typedef enum logic [1:0] {
      POOL_HOLD,
      POOL_TAKE,
      POOL_GIVE_CUR,
      POOL_GIVE_HEAD
   } pool_op_type;

   typedef enum logic [2:0] {
      RES_HOLD,
      RES_FOUND,
      RES_READ_ENTRY,
      RES_READ_DIRECT,
      RES_EXHAUSTED
   } res_op_type;

   typedef struct packed {
      logic         load_req;
      rec_op_type   rec_op;
      walk_op_type  walk_op;
      rd_sel_type   rd_sel;
      link_wr_type  link_wr;
      val_wr_type   val_wr;
      pool_op_type  pool_op;
      res_op_type   res_op;
      logic         set_wr;
      logic         out_load;
   } dp_ctl_type;

   typedef struct packed {
      cmd_type   cmd;
      mode_type  mode;
      logic      direct_match;
      logic      entry_match;
      logic      idx_last;
      logic      idx_pos;
      logic      pos_oor;
      logic      free_ge1;
      logic      free_ge2;
      logic      len_le1;
      logic      out_free;
   } dp_sts_type;

endpackage

FILE: hw/rtl/plvs_req_if.sv
interface plvs_req_if;
   logic                              valid;
   logic                              ready;
   logic [plvs_pkg::CmdW-1:0]         cmd;
   logic [plvs_pkg::SetAw-1:0]        set_id;
   logic [plvs_pkg::ValueW-1:0]       item_value;
   logic [plvs_pkg::PosW-1:0]         position;

   modport source (output valid, cmd, set_id, item_value, position, input ready);
   modport sink (input valid, cmd, set_id, item_value, position, output ready);
endinterface

FILE: hw/rtl/plvs_rsp_if.sv
interface plvs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              found;
   logic [plvs_pkg::ValueW-1:0]       read_value;
   logic [plvs_pkg::LenW-1:0]         set_size;
   logic                              status;

   modport source (output valid, found, read_value, set_size, status, input ready);
   modport sink (input valid, found, read_value, set_size, status, output ready);
endinterface

FILE: hw/rtl/plvs_datapath.sv
module plvs_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  plvs_pkg::dp_ctl_type            ctl,
   output plvs_pkg::dp_sts_type            sts,
   input  logic [plvs_pkg::CmdW-1:0]       req_cmd,
   input  logic [plvs_pkg::SetAw-1:0]      req_set_id,
   input  logic [plvs_pkg::ValueW-1:0]     req_item_value,
   input  logic [plvs_pkg::PosW-1:0]       req_position,
   plvs_rsp_if.source                      rsp_bus
);

   logic [plvs_pkg::CmdW-1:0]     cmd_ff;
   logic [plvs_pkg::SetAw-1:0]    set_id_ff;
   logic [plvs_pkg::ValueW-1:0]   value_ff;
   logic [plvs_pkg::PosW-1:0]     pos_ff;

   plvs_pkg::set_rec_type         set_mem [plvs_pkg::SetCount];
   plvs_pkg::set_rec_type         set_rd_ff;
   logic [plvs_pkg::SetCount-1:0] set_valid_ff;
   plvs_pkg::set_rec_type         set_view;
   plvs_pkg::set_rec_type         rec_ff;
   plvs_pkg::set_rec_type         rec_in;

   logic [plvs_pkg::ValueW-1:0]   val_mem [plvs_pkg::PoolSize];
   logic [plvs_pkg::LinkW-1:0]    link_mem [plvs_pkg::PoolSize];
   logic [plvs_pkg::ValueW-1:0]   val_rd_ff;
   logic [plvs_pkg::LinkW-1:0]    link_rd_ff;
   logic                          fresh_ff;
   logic [plvs_pkg::EntryAw-1:0]  rd_addr_ff;
   logic [plvs_pkg::EntryAw-1:0]  rd_addr;
   logic [plvs_pkg::LinkW-1:0]    link_out;

   logic                          lw_en;
   logic [plvs_pkg::EntryAw-1:0]  lw_addr;
   logic [plvs_pkg::LinkW-1:0]    lw_data;
   logic                          vw_en;
   logic [plvs_pkg::EntryAw-1:0]  vw_addr;
   logic [plvs_pkg::ValueW-1:0]   vw_data;

   logic [plvs_pkg::LinkW-1:0]    free_head_ff;
   logic [plvs_pkg::LenW-1:0]     free_count_ff;
   logic [plvs_pkg::LinkW-1:0]    fill_ff;
   logic [plvs_pkg::EntryAw-1:0]  node_a_ff;
   logic [plvs_pkg::EntryAw-1:0]  node_b_ff;

   logic [plvs_pkg::LinkW-1:0]    cur_ff;
   logic [plvs_pkg::LinkW-1:0]    prev_ff;
   logic [plvs_pkg::LenW-1:0]     idx_ff;

   logic                          found_ff;
   logic [plvs_pkg::ValueW-1:0]   read_ff;
   logic                          status_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_found_ff;
   logic [plvs_pkg::ValueW-1:0]   rsp_read_ff;
   logic [plvs_pkg::LenW-1:0]     rsp_size_ff;
   logic                          rsp_status_ff;

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         cmd_ff    <= req_cmd;
         set_id_ff <= req_set_id;
         value_ff  <= req_item_value;
         pos_ff    <= req_position;
      end
   end

   // set table, entries never written read as empty
   always_ff @(posedge clock) begin
      if (ctl.set_wr) begin
         set_mem[set_id_ff] <= rec_ff;
      end
      if (ctl.load_req) begin
         set_rd_ff <= set_mem[req_set_id];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_valid_ff <= '0;
      end else if (ctl.set_wr) begin
         set_valid_ff[set_id_ff] <= 1'b1;
      end
   end

   assign set_view = set_valid_ff[set_id_ff] ? set_rd_ff : '0;

   always_comb begin
      rec_in = rec_ff;
      unique case (ctl.rec_op)
         plvs_pkg::REC_HOLD: begin
         end
         plvs_pkg::REC_LOAD: begin
            rec_in = set_view;
         end
         plvs_pkg::REC_DIRECT: begin
            rec_in.mode   = plvs_pkg::MODE_DIRECT;
            rec_in.direct = value_ff;
            rec_in.length = plvs_pkg::LenW'(1);
         end
         plvs_pkg::REC_EMPTY: begin
            rec_in.mode   = plvs_pkg::MODE_EMPTY;
            rec_in.direct = '0;
            rec_in.length = '0;
         end
         plvs_pkg::REC_PROMOTE: begin
            rec_in.mode   = plvs_pkg::MODE_LIST;
            rec_in.direct = '0;
            rec_in.head   = node_a_ff;
            rec_in.tail   = node_b_ff;
            rec_in.length = plvs_pkg::LenW'(2);
         end
         plvs_pkg::REC_APPEND: begin
            rec_in.tail   = node_b_ff;
            rec_in.length = rec_ff.length + plvs_pkg::LenW'(1);
         end
         plvs_pkg::REC_UNLINK: begin
            if (prev_ff == plvs_pkg::NilLink) begin
               rec_in.head = link_out[plvs_pkg::EntryAw-1:0];
            end
            if (cur_ff[plvs_pkg::EntryAw-1:0] == rec_ff.tail) begin
               rec_in.tail = prev_ff[plvs_pkg::EntryAw-1:0];
            end
            rec_in.length = rec_ff.length - plvs_pkg::LenW'(1);
         end
         plvs_pkg::REC_COLLAPSE: begin
            rec_in.mode   = plvs_pkg::MODE_DIRECT;
            rec_in.direct = val_rd_ff;
            rec_in.length = plvs_pkg::LenW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   // entry pool
   always_comb begin
      unique case (ctl.rd_sel)
         plvs_pkg::RD_CUR:  rd_addr = cur_ff[plvs_pkg::EntryAw-1:0];
         plvs_pkg::RD_FREE: rd_addr = free_head_ff[plvs_pkg::EntryAw-1:0];
         plvs_pkg::RD_HEAD: rd_addr = rec_ff.head;
         default:           rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_sel != plvs_pkg::RD_NONE) begin
         val_rd_ff  <= val_mem[rd_addr];
         link_rd_ff <= link_mem[rd_addr];
         rd_addr_ff <= rd_addr;
         fresh_ff   <= {1'b0, rd_addr} >= fill_ff;
      end
   end

   // untouched entries still chain to the next one
   assign link_out = fresh_ff ? ({1'b0, rd_addr_ff} + plvs_pkg::LinkW'(1)) : link_rd_ff;

   always_comb begin
      lw_en   = 1'b1;
      lw_addr = '0;
      lw_data = '0;
      unique case (ctl.link_wr)
         plvs_pkg::LW_NONE: begin
            lw_en = 1'b0;
         end
         plvs_pkg::LW_PREV_NXT: begin
            lw_en   = prev_ff != plvs_pkg::NilLink;
            lw_addr = prev_ff[plvs_pkg::EntryAw-1:0];
            lw_data = link_out;
         end
         plvs_pkg::LW_GIVE_CUR: begin
            lw_addr = cur_ff[plvs_pkg::EntryAw-1:0];
            lw_data = free_head_ff;
         end
         plvs_pkg::LW_GIVE_HEAD: begin
            lw_addr = rec_ff.head;
            lw_data = free_head_ff;
         end
         plvs_pkg::LW_A_B: begin
            lw_addr = node_a_ff;
            lw_data = {1'b0, node_b_ff};
         end
         plvs_pkg::LW_TAIL_B: begin
            lw_addr = rec_ff.tail;
            lw_data = {1'b0, node_b_ff};
         end
         default: begin
            lw_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      vw_en   = 1'b1;
      vw_addr = node_b_ff;
      vw_data = value_ff;
      unique case (ctl.val_wr)
         plvs_pkg::VW_NONE: begin
            vw_en = 1'b0;
         end
         plvs_pkg::VW_A_DIRECT: begin
            vw_addr = node_a_ff;
            vw_data = rec_ff.direct;
         end
         plvs_pkg::VW_B_VALUE: begin
         end
         default: begin
            vw_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (lw_en) begin
         link_mem[lw_addr] <= lw_data;
      end
      if (vw_en) begin
         val_mem[vw_addr] <= vw_data;
      end
   end

   // free list
   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= '0;
         free_count_ff <= plvs_pkg::LenW'(plvs_pkg::PoolSize);
         fill_ff       <= '0;
      end else begin
         unique case (ctl.pool_op)
            plvs_pkg::POOL_HOLD: begin
            end
            plvs_pkg::POOL_TAKE: begin
               free_head_ff  <= link_out;
               free_count_ff <= free_count_ff - plvs_pkg::LenW'(1);
               if (free_head_ff == fill_ff) begin
                  fill_ff <= fill_ff + plvs_pkg::LinkW'(1);
               end
            end
            plvs_pkg::POOL_GIVE_CUR: begin
               free_head_ff  <= cur_ff;
               free_count_ff <= free_count_ff + plvs_pkg::LenW'(1);
            end
            plvs_pkg::POOL_GIVE_HEAD: begin
               free_head_ff  <= {1'b0, rec_ff.head};
               free_count_ff <= free_count_ff + plvs_pkg::LenW'(1);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.pool_op == plvs_pkg::POOL_TAKE) begin
         node_a_ff <= node_b_ff;
         node_b_ff <= free_head_ff[plvs_pkg::EntryAw-1:0];
      end
   end

   // list walk
   always_ff @(posedge clock) begin
      unique case (ctl.walk_op)
         plvs_pkg::WALK_HOLD: begin
         end
         plvs_pkg::WALK_START: begin
            cur_ff  <= {1'b0, rec_ff.head};
            prev_ff <= plvs_pkg::NilLink;
            idx_ff  <= '0;
         end
         plvs_pkg::WALK_NEXT: begin
            cur_ff  <= link_out;
            prev_ff <= cur_ff;
            idx_ff  <= idx_ff + plvs_pkg::LenW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         found_ff  <= 1'b0;
         read_ff   <= '0;
         status_ff <= 1'b0;
      end else begin
         unique case (ctl.res_op)
            plvs_pkg::RES_HOLD:        begin end
            plvs_pkg::RES_FOUND:       found_ff  <= 1'b1;
            plvs_pkg::RES_READ_ENTRY:  read_ff   <= val_rd_ff;
            plvs_pkg::RES_READ_DIRECT: read_ff   <= rec_ff.direct;
            plvs_pkg::RES_EXHAUSTED:   status_ff <= 1'b1;
            default:                   begin end
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_found_ff  <= found_ff;
         rsp_read_ff   <= read_ff;
         rsp_size_ff   <= rec_ff.length;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.found      = rsp_found_ff;
   assign rsp_bus.read_value = rsp_read_ff;
   assign rsp_bus.set_size   = rsp_size_ff;
   assign rsp_bus.status     = rsp_status_ff;

   always_comb begin
      sts.cmd          = plvs_pkg::cmd_type'(cmd_ff);
      sts.mode         = rec_ff.mode;
      sts.direct_match = rec_ff.direct == value_ff;
      sts.entry_match  = val_rd_ff == value_ff;
      sts.idx_last     = (idx_ff + plvs_pkg::LenW'(1)) == rec_ff.length;
      sts.idx_pos      = idx_ff == plvs_pkg::LenW'(pos_ff);
      sts.pos_oor      = plvs_pkg::LenW'(pos_ff) >= rec_ff.length;
      sts.free_ge1     = free_count_ff != '0;
      sts.free_ge2     = free_count_ff >= plvs_pkg::LenW'(2);
      sts.len_le1      = rec_ff.length <= plvs_pkg::LenW'(1);
      sts.out_free     = !rsp_valid_ff || rsp_bus.ready;
   end

endmodule

FILE: hw/rtl/plvs_controller.sv
module plvs_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output plvs_pkg::dp_ctl_type  ctl,
   input  plvs_pkg::dp_sts_type  sts
);

   plvs_pkg::ctl_state_type state_ff;
   plvs_pkg::ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plvs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         plvs_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            ctl.load_req = req_valid;
            if (req_valid) begin
               state_in = plvs_pkg::ST_SET_READ;
            end
         end
         plvs_pkg::ST_SET_READ: begin
            ctl.rec_op = plvs_pkg::REC_LOAD;
            state_in   = plvs_pkg::ST_DECODE;
         end
         plvs_pkg::ST_DECODE: begin
            state_in = plvs_pkg::ST_DONE;
            if (sts.mode == plvs_pkg::MODE_LIST && sts.cmd != plvs_pkg::CMD_COUNT
                && !(sts.cmd == plvs_pkg::CMD_GET_NTH && sts.pos_oor)) begin
               ctl.walk_op = plvs_pkg::WALK_START;
               if (sts.cmd == plvs_pkg::CMD_ADD || sts.cmd == plvs_pkg::CMD_REMOVE
                   || sts.cmd == plvs_pkg::CMD_EXISTS || sts.cmd == plvs_pkg::CMD_GET_NTH
                   || sts.cmd == plvs_pkg::CMD_CLEAR) begin
                  state_in = plvs_pkg::ST_WALK_REQ;
               end
            end else begin
               unique case (sts.cmd)
                  plvs_pkg::CMD_ADD: begin
                     if (sts.mode == plvs_pkg::MODE_DIRECT) begin
                        if (!sts.direct_match) begin
                           if (sts.free_ge2) begin
                              state_in = plvs_pkg::ST_AL1_REQ;
                           end else begin
                              ctl.res_op = plvs_pkg::RES_EXHAUSTED;
                           end
                        end
                     end else begin
                        ctl.rec_op = plvs_pkg::REC_DIRECT;
                        state_in   = plvs_pkg::ST_SET_WRITE;
                     end
                  end
                  plvs_pkg::CMD_REMOVE: begin
                     if (sts.mode == plvs_pkg::MODE_DIRECT && sts.direct_match) begin
                        ctl.rec_op = plvs_pkg::REC_EMPTY;
                        state_in   = plvs_pkg::ST_SET_WRITE;
                     end
                  end
                  plvs_pkg::CMD_EXISTS: begin
                     if (sts.mode == plvs_pkg::MODE_DIRECT && sts.direct_match) begin
                        ctl.res_op = plvs_pkg::RES_FOUND;
                     end
                  end
                  plvs_pkg::CMD_GET_NTH: begin
                     if (sts.mode == plvs_pkg::MODE_DIRECT && !sts.pos_oor) begin
                        ctl.res_op = plvs_pkg::RES_READ_DIRECT;
                     end
                  end
                  plvs_pkg::CMD_CLEAR: begin
                     ctl.rec_op = plvs_pkg::REC_EMPTY;
                     state_in   = plvs_pkg::ST_SET_WRITE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         plvs_pkg::ST_WALK_REQ: begin
            ctl.rd_sel = plvs_pkg::RD_CUR;
            state_in   = plvs_pkg::ST_WALK_CHK;
         end
         plvs_pkg::ST_WALK_CHK: begin
            state_in = plvs_pkg::ST_DONE;
            unique case (sts.cmd)
               plvs_pkg::CMD_ADD, plvs_pkg::CMD_REMOVE, plvs_pkg::CMD_EXISTS: begin
                  priority if (sts.entry_match) begin
                     if (sts.cmd == plvs_pkg::CMD_EXISTS) begin
                        ctl.res_op = plvs_pkg::RES_FOUND;
                     end
                     if (sts.cmd == plvs_pkg::CMD_REMOVE) begin
                        state_in = plvs_pkg::ST_RM_LINK;
                     end
                  end else if (sts.idx_last) begin
                     if (sts.cmd == plvs_pkg::CMD_ADD) begin
                        if (sts.free_ge1) begin
                           state_in = plvs_pkg::ST_AL2_REQ;
                        end else begin
                           ctl.res_op = plvs_pkg::RES_EXHAUSTED;
                        end
                     end
                  end else begin
                     ctl.walk_op = plvs_pkg::WALK_NEXT;
                     state_in    = plvs_pkg::ST_WALK_REQ;
                  end
               end
               plvs_pkg::CMD_GET_NTH: begin
                  if (sts.idx_pos) begin
                     ctl.res_op = plvs_pkg::RES_READ_ENTRY;
                  end else begin
                     ctl.walk_op = plvs_pkg::WALK_NEXT;
                     state_in    = plvs_pkg::ST_WALK_REQ;
                  end
               end
               plvs_pkg::CMD_CLEAR: begin
                  ctl.link_wr = plvs_pkg::LW_GIVE_CUR;
                  ctl.pool_op = plvs_pkg::POOL_GIVE_CUR;
                  ctl.walk_op = plvs_pkg::WALK_NEXT;
                  if (sts.idx_last) begin
                     ctl.rec_op = plvs_pkg::REC_EMPTY;
                     state_in   = plvs_pkg::ST_SET_WRITE;
                  end else begin
                     state_in = plvs_pkg::ST_WALK_REQ;
                  end
               end
               default: begin
               end
            endcase
         end
         plvs_pkg::ST_RM_LINK: begin
            ctl.link_wr = plvs_pkg::LW_PREV_NXT;
            ctl.rec_op  = plvs_pkg::REC_UNLINK;
            state_in    = plvs_pkg::ST_RM_FREE;
         end
         plvs_pkg::ST_RM_FREE: begin
            ctl.link_wr = plvs_pkg::LW_GIVE_CUR;
            ctl.pool_op = plvs_pkg::POOL_GIVE_CUR;
            state_in    = sts.len_le1 ? plvs_pkg::ST_COL_REQ : plvs_pkg::ST_SET_WRITE;
         end
         plvs_pkg::ST_COL_REQ: begin
            ctl.rd_sel = plvs_pkg::RD_HEAD;
            state_in   = plvs_pkg::ST_COL_CHK;
         end
         plvs_pkg::ST_COL_CHK: begin
            ctl.rec_op  = plvs_pkg::REC_COLLAPSE;
            ctl.link_wr = plvs_pkg::LW_GIVE_HEAD;
            ctl.pool_op = plvs_pkg::POOL_GIVE_HEAD;
            state_in    = plvs_pkg::ST_SET_WRITE;
         end
         plvs_pkg::ST_AL1_REQ: begin
            ctl.rd_sel = plvs_pkg::RD_FREE;
            state_in   = plvs_pkg::ST_AL1_GET;
         end
         plvs_pkg::ST_AL1_GET: begin
            ctl.pool_op = plvs_pkg::POOL_TAKE;
            state_in    = plvs_pkg::ST_AL2_REQ;
         end
         plvs_pkg::ST_AL2_REQ: begin
            ctl.rd_sel = plvs_pkg::RD_FREE;
            state_in   = plvs_pkg::ST_AL2_GET;
         end
         plvs_pkg::ST_AL2_GET: begin
            ctl.pool_op = plvs_pkg::POOL_TAKE;
            state_in    = (sts.mode == plvs_pkg::MODE_DIRECT) ? plvs_pkg::ST_PRO_W1
                                                               : plvs_pkg::ST_APPEND;
         end
         plvs_pkg::ST_PRO_W1: begin
            ctl.val_wr  = plvs_pkg::VW_A_DIRECT;
            ctl.link_wr = plvs_pkg::LW_A_B;
            state_in    = plvs_pkg::ST_PRO_W2;
         end
         plvs_pkg::ST_PRO_W2: begin
            ctl.val_wr = plvs_pkg::VW_B_VALUE;
            ctl.rec_op = plvs_pkg::REC_PROMOTE;
            state_in   = plvs_pkg::ST_SET_WRITE;
         end
         plvs_pkg::ST_APPEND: begin
            ctl.val_wr  = plvs_pkg::VW_B_VALUE;
            ctl.link_wr = plvs_pkg::LW_TAIL_B;
            ctl.rec_op  = plvs_pkg::REC_APPEND;
            state_in    = plvs_pkg::ST_SET_WRITE;
         end
         plvs_pkg::ST_SET_WRITE: begin
            ctl.set_wr = 1'b1;
            state_in   = plvs_pkg::ST_DONE;
         end
         plvs_pkg::ST_DONE: begin
            if (sts.out_free) begin
               ctl.out_load = 1'b1;
               state_in     = plvs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plvs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/pooled_linked_value_set_core.sv
// Keeps 64 sets of 32-bit values; a set is empty, holds one value in the set table, or holds
// a linked list of entries taken from a shared pool of 1024 entries with a free list. One item
// at a time: count and commands on empty or single-value sets read and, when the set changes,
// write back the set table; exists, remove, add, get nth and clear on a list walk the list, and
// each step of the walk is one registered read of the entry memories. Appending to a list takes
// one entry from the free list after the walk, turning a single value into a list takes two, and
// remove unlinks the entry and returns it to the free list, and also returns the last entry when
// the list falls back to one value. A finished result waits while the output register still
// holds an unaccepted one; a new item is taken once the result is in the output register.
// No clearing pass is needed after reset. status reports an add dropped because the pool ran
// out.
module pooled_linked_value_set_core (
   input  logic         clock,
   input  logic         reset,
   plvs_req_if.sink     req_bus,
   plvs_rsp_if.source   rsp_bus
);

   plvs_pkg::dp_ctl_type ctl;
   plvs_pkg::dp_sts_type sts;

   plvs_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   plvs_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .sts            (sts),
      .req_cmd        (req_bus.cmd),
      .req_set_id     (req_bus.set_id),
      .req_item_value (req_bus.item_value),
      .req_position   (req_bus.position),
      .rsp_bus        (rsp_bus)
   );

endmodule

FILE: hw/rtl/plvs_checker.sv
module plvs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_found,
   input logic [plvs_pkg::ValueW-1:0]    rsp_read_value,
   input logic [plvs_pkg::LenW-1:0]      rsp_set_size,
   input logic                           rsp_status
);

   // one item in flight
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken twice in a row");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_read_value) && $stable(rsp_set_size) && $stable(rsp_status))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_read_value == '0 && rsp_set_size != '0 && !rsp_status)
      else $error("found result inconsistent");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind pooled_linked_value_set_core plvs_checker u_plvs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_found      (rsp_bus.found),
   .rsp_read_value (rsp_bus.read_value),
   .rsp_set_size   (rsp_bus.set_size),
   .rsp_status     (rsp_bus.status)
);

FILE: tb/sv/pooled_linked_value_set_core_tb.sv
`timescale 1ns / 1ps

typedef struct {
   logic                        found;
   logic [plvs_pkg::ValueW-1:0] read_value;
   logic [plvs_pkg::LenW-1:0]   set_size;
   logic                        status;
} set_answer_type;

class set_scoreboard_type;
   logic [plvs_pkg::ValueW-1:0] members[plvs_pkg::SetCount][$];
   int                          free_entries;
   set_answer_type              pending_answers[$];
   int                          errors;
   int                          checked;
   int                          dropped_adds;

   function new();
      free_entries = plvs_pkg::PoolSize;
      errors = 0;
      checked = 0;
      dropped_adds = 0;
   endfunction

   function automatic int find_member(int s, logic [plvs_pkg::ValueW-1:0] v);
      foreach (members[s][i])
         if (members[s][i] == v) return i;
      return -1;
   endfunction

   function automatic void note_request(logic [plvs_pkg::CmdW-1:0] c,
                                        logic [plvs_pkg::SetAw-1:0] s,
                                        logic [plvs_pkg::ValueW-1:0] v,
                                        logic [plvs_pkg::PosW-1:0] p);
      set_answer_type a;
      int idx;
      int n;
      a = '{found: 1'b0, read_value: '0, set_size: '0, status: 1'b0};
      idx = find_member(s, v);
      n = members[s].size();
      case (plvs_pkg::cmd_type'(c))
         plvs_pkg::CMD_ADD: begin
            if (idx < 0) begin
               if (n == 0) members[s].push_back(v);
               else if (n == 1 && free_entries < 2) a.status = 1'b1;
               else if (n >= 2 && free_entries < 1) a.status = 1'b1;
               else begin
                  free_entries -= (n == 1) ? 2 : 1;
                  members[s].push_back(v);
               end
            end
            if (a.status) dropped_adds++;
         end
         plvs_pkg::CMD_REMOVE: begin
            if (idx >= 0) begin
               if (n == 2) free_entries += 2;
               else if (n > 2) free_entries += 1;
               members[s].delete(idx);
            end
         end
         plvs_pkg::CMD_EXISTS: a.found = (idx >= 0);
         plvs_pkg::CMD_GET_NTH: if (p < n) a.read_value = members[s][p];
         plvs_pkg::CMD_CLEAR: begin
            if (n >= 2) free_entries += n;
            members[s].delete();
         end
         default: ;
      endcase
      a.set_size = members[s].size();
      pending_answers.push_back(a);
   endfunction

   function automatic void check_answer(logic f, logic [plvs_pkg::ValueW-1:0] rd,
                                        logic [plvs_pkg::LenW-1:0] sz, logic st);
      set_answer_type e;
      checked++;
      if (pending_answers.size() == 0) begin
         $display("%0t: unexpected item found=%0d read_value=%h set_size=%0d status=%0d",
                  $time, f, rd, sz, st);
         errors++;
         return;
      end
      e = pending_answers.pop_front();
      if (f !== e.found) begin
         $display("%0t: found exp %0d got %0d", $time, e.found, f);
         errors++;
      end
      if (rd !== e.read_value) begin
         $display("%0t: read_value exp %h got %h", $time, e.read_value, rd);
         errors++;
      end
      if (sz !== e.set_size) begin
         $display("%0t: set_size exp %0d got %0d", $time, e.set_size, sz);
         errors++;
      end
      if (st !== e.status) begin
         $display("%0t: status exp %0d got %0d", $time, e.status, st);
         errors++;
      end
   endfunction
endclass

module pooled_linked_value_set_core_tb;
   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   no_gaps = 1'b0;
   int   ready_hold = 0;
   int   sent = 0;
   logic [plvs_pkg::ValueW-1:0] value_pool[16];

   set_scoreboard_type sb = new();

   plvs_req_if req_bus();
   plvs_rsp_if rsp_bus();

   pooled_linked_value_set_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.cmd = '0;
      req_bus.set_id = '0;
      req_bus.item_value = '0;
      req_bus.position = '0;
      rsp_bus.ready = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         sb.note_request(req_bus.cmd, req_bus.set_id, req_bus.item_value, req_bus.position);
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_answer(rsp_bus.found, rsp_bus.read_value, rsp_bus.set_size,
                         rsp_bus.status);
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (no_gaps) begin
         rsp_bus.ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 9) < 7) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         ready_hold <= pick_gap();
         rsp_bus.ready <= 1'b0;
      end
   end

   // entered and left at a falling edge
   task automatic send_cmd(input plvs_pkg::cmd_type c, input logic [plvs_pkg::SetAw-1:0] s,
                           input logic [plvs_pkg::ValueW-1:0] v,
                           input logic [plvs_pkg::PosW-1:0] p);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= c;
      req_bus.set_id <= s;
      req_bus.item_value <= v;
      req_bus.position <= p;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending_answers.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic random_item();
      int r;
      plvs_pkg::cmd_type c;
      logic [plvs_pkg::SetAw-1:0] s;
      logic [plvs_pkg::ValueW-1:0] v;
      logic [plvs_pkg::PosW-1:0] p;
      r = $urandom_range(0, 99);
      if (r < 40) c = plvs_pkg::CMD_ADD;
      else if (r < 58) c = plvs_pkg::CMD_REMOVE;
      else if (r < 72) c = plvs_pkg::CMD_EXISTS;
      else if (r < 78) c = plvs_pkg::CMD_COUNT;
      else if (r < 92) c = plvs_pkg::CMD_GET_NTH;
      else if (r < 96) c = plvs_pkg::CMD_CLEAR;
      else c = plvs_pkg::cmd_type'($urandom_range(6, 7));
      s = ($urandom_range(0, 3) != 0) ? plvs_pkg::SetAw'($urandom_range(0, 7))
                                      : plvs_pkg::SetAw'($urandom);
      v = ($urandom_range(0, 4) != 0) ? value_pool[$urandom_range(0, 15)] : $urandom;
      p = ($urandom_range(0, 4) != 0) ? plvs_pkg::PosW'($urandom_range(0, 12))
                                      : plvs_pkg::PosW'($urandom);
      send_cmd(c, s, v, p);
   endtask

   initial begin
      foreach (value_pool[i]) value_pool[i] = $urandom;
      value_pool[0] = '0;
      value_pool[1] = '1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, promotion, collapse, misses
      send_cmd(plvs_pkg::CMD_COUNT, 6'd0, '0, '0);
      send_cmd(plvs_pkg::CMD_GET_NTH, 6'd0, '0, '0);
      send_cmd(plvs_pkg::CMD_REMOVE, 6'd0, '0, '0);
      send_cmd(plvs_pkg::CMD_ADD, 6'd63, '1, '1);
      send_cmd(plvs_pkg::CMD_ADD, 6'd63, '1, '0);
      send_cmd(plvs_pkg::CMD_EXISTS, 6'd63, '1, '0);
      send_cmd(plvs_pkg::CMD_ADD, 6'd63, '0, '0);
      send_cmd(plvs_pkg::CMD_ADD, 6'd63, 32'h5555_aaaa, '0);
      send_cmd(plvs_pkg::CMD_ADD, 6'd63, 32'haaaa_5555, '0);
      send_cmd(plvs_pkg::CMD_GET_NTH, 6'd63, '0, 10'd3);
      send_cmd(plvs_pkg::CMD_GET_NTH, 6'd63, '0, '1);
      send_cmd(plvs_pkg::CMD_EXISTS, 6'd63, 32'h1234_5678, '0);
      send_cmd(plvs_pkg::CMD_REMOVE, 6'd63, 32'h1234_5678, '0);
      send_cmd(plvs_pkg::CMD_REMOVE, 6'd63, 32'h5555_aaaa, '0);
      send_cmd(plvs_pkg::CMD_REMOVE, 6'd63, 32'haaaa_5555, '0);
      send_cmd(plvs_pkg::CMD_REMOVE, 6'd63, '1, '0);
      send_cmd(plvs_pkg::CMD_GET_NTH, 6'd63, '0, '0);
      send_cmd(plvs_pkg::CMD_ADD, 6'd63, 32'h0f0f_0f0f, '0);
      send_cmd(plvs_pkg::cmd_type'(3'd6), 6'd63, '1, '1);
      send_cmd(plvs_pkg::cmd_type'(3'd7), 6'd63, '1, '1);
      send_cmd(plvs_pkg::CMD_CLEAR, 6'd63, '0, '0);
      send_cmd(plvs_pkg::CMD_CLEAR, 6'd63, '0, '0);
      drain();

      // long lists on a few sets, then hits at both ends
      no_gaps = 1'b1;
      for (int s = 0; s < 8; s++)
         for (int k = 0; k < 16; k++)
            send_cmd(plvs_pkg::CMD_ADD, plvs_pkg::SetAw'(s), {s[15:0], k[15:0]}, '0);
      no_gaps = 1'b0;
      send_cmd(plvs_pkg::CMD_ADD, 6'd3, {16'd3, 16'd15}, '0);
      send_cmd(plvs_pkg::CMD_GET_NTH, 6'd5, '0, 10'd15);
      send_cmd(plvs_pkg::CMD_EXISTS, 6'd7, {16'd7, 16'd15}, '0);
      send_cmd(plvs_pkg::CMD_REMOVE, 6'd7, {16'd7, 16'd0}, '0);
      send_cmd(plvs_pkg::CMD_REMOVE, 6'd6, {16'd6, 16'd15}, '0);
      send_cmd(plvs_pkg::CMD_GET_NTH, 6'd6, '0, 10'd14);
      for (int s = 0; s < 8; s++)
         send_cmd(plvs_pkg::CMD_CLEAR, plvs_pkg::SetAw'(s), '0, '0);
      drain();

      // random traffic with a stretch of back-to-back items in the middle
      for (int i = 0; i < 580; i++) begin
         no_gaps = (i >= 250 && i < 330);
         random_item();
         if (i == 400) drain();
      end
      drain();

      $display("tb: %0d items sent, %0d answers checked over directed and random traffic",
               sent, sb.checked);
      $display("tb: %0d adds dropped on a full pool", sb.dropped_adds);
      if (sb.errors == 0 && sb.pending_answers.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end
endmodule
